### hw/rtl/drg_pkg.sv
// Shared constants for the damaged read generator: twister, register map, base codes.
package drg_pkg;

    localparam int DEF_MAX_READ_LENGTH = 64;
    localparam int DEF_PROB_BITS       = 16;

    // 64-bit Mersenne Twister
    localparam int          TW_N       = 312;
    localparam int          TW_M       = 156;
    localparam int          TW_IDX_W   = 9;
    localparam logic [63:0] TW_MAG     = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] TW_SEED_MUL = 64'h5851_F42D_4C95_7F2D;

    // register indexes
    localparam logic [2:0] REG_SEED    = 3'd0;
    localparam logic [2:0] REG_LENGTH  = 3'd1;
    localparam logic [2:0] REG_COMP    = 3'd2;
    localparam logic [2:0] REG_FIVE_CT = 3'd3;
    localparam logic [2:0] REG_GA3     = 3'd4;
    localparam logic [2:0] REG_CT3     = 3'd5;
    localparam logic [2:0] REG_RATES   = 3'd6;

    // register reset values
    localparam logic [63:0] RST_SEED    = 64'd1;
    localparam logic [6:0]  RST_LENGTH  = 7'd60;
    localparam logic [32:0] RST_COMP    = 33'd3006493491;
    localparam logic [31:0] RST_FIVE_CT = 32'd3026595348;
    localparam logic [31:0] RST_GA3     = 32'd3026595348;
    localparam logic [31:0] RST_CT3     = 32'd3026583552;
    localparam logic [63:0] RST_RATES   = 64'd4325442;

    // nucleotide codes
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    function automatic logic [63:0] tw_temper(input logic [63:0] w);
        logic [63:0] x;
        x = w;
        x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
        x = x ^ ((x << 17) & 64'h71D6_7FFF_EDA6_0000);
        x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
        x = x ^ (x >> 43);
        return x;
    endfunction

endpackage

### hw/rtl/drg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module drg_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/damaged_read_generator_unit.sv
// Top level of the damaged read generator: APB registers, twister and read sequencer.
//
//  channel   | direction | beat holds
//  s_*       | in        | tdata[15:0] tag
//  m_*       | out       | tdata read_tag, base, position, is_damaged; tlast last base
//  APB       | in/out    | register writes at 8*index, reads return the register
//
// Each twister draw passes ST_DRAW_A and ST_DRAW_B; a base is fetched in ST_FETCH
//   and ST_LOAD, handed over in ST_EMIT. A read draws its damage flag, its bases,
//   then any depurination draw and, base by base, background and damage draws.
// After TW_N draws the twister regenerates its memory, paced by its one read port.
// After a curve register write the next read first rebuilds the curve tables.
// Reset and each seed write run a seeding pass, each word after the seed built from
//   three partial products; no request is taken during it.
// A stalled result holds the sequencer; one result register parts the two sides.
module damaged_read_generator_unit #(
    parameter int MAX_READ_LENGTH = drg_pkg::DEF_MAX_READ_LENGTH,
    parameter int PROB_BITS       = drg_pkg::DEF_PROB_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] tag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] read_tag, [17:16] base, [23:18] position,
                                   // [24] is_damaged, [31:25] zero
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    import drg_pkg::*;

    localparam int AW = (MAX_READ_LENGTH > 1) ? $clog2(MAX_READ_LENGTH) : 1;
    localparam int CW = $clog2(MAX_READ_LENGTH + 1);
    localparam int PB = PROB_BITS;

    localparam logic [3:0] ST_SEED   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_BUILD  = 4'd2;
    localparam logic [3:0] ST_DRAW_A = 4'd3;
    localparam logic [3:0] ST_DRAW_B = 4'd4;
    localparam logic [3:0] ST_REGEN  = 4'd5;
    localparam logic [3:0] ST_FETCH  = 4'd6;
    localparam logic [3:0] ST_LOAD   = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    localparam logic [3:0] OP_ANC  = 4'd0;
    localparam logic [3:0] OP_BASE = 4'd1;
    localparam logic [3:0] OP_DEP  = 4'd2;
    localparam logic [3:0] OP_DEPB = 4'd3;
    localparam logic [3:0] OP_BGC  = 4'd4;
    localparam logic [3:0] OP_FIVE = 4'd5;
    localparam logic [3:0] OP_CT3  = 4'd6;
    localparam logic [3:0] OP_BGG  = 4'd7;
    localparam logic [3:0] OP_GA3  = 4'd8;
    localparam logic [3:0] OP_OXO  = 4'd9;

    localparam logic [TW_IDX_W-1:0] TW_LAST = TW_IDX_W'(TW_N - 1);
    localparam logic [TW_IDX_W-1:0] TW_END  = TW_IDX_W'(TW_N);
    localparam logic [TW_IDX_W-1:0] TW_OFS  = TW_IDX_W'(TW_M);
    localparam logic [CW-1:0]       LEN_MAX = CW'(MAX_READ_LENGTH);

    // configuration registers
    logic [63:0] seed_reg;
    logic [6:0]  length_reg;
    logic [32:0] comp_reg;
    logic [31:0] five_cfg_reg, ga_cfg_reg, ct_cfg_reg;
    logic [63:0] rates_reg;
    logic        curves_valid_reg, curves_valid_next;

    // sequencer
    logic [3:0]          st_reg, st_next;
    logic [3:0]          op_reg, op_next;
    logic [1:0]          ph_reg, ph_next;
    logic [TW_IDX_W-1:0] cnt_reg, cnt_next;
    logic [TW_IDX_W-1:0] idx_reg, idx_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [15:0]         tag_reg, tag_next;
    logic                anc_reg, anc_next;
    logic [1:0]          base0_reg, base0_next;
    logic [1:0]          cur_reg, cur_next;
    logic [15:0]         five_reg, five_next, ga_reg, ga_next, ct_reg, ct_next;
    logic [63:0]         pw_reg, pw_next;
    logic [63:0]         acc_reg, acc_next;
    logic [32:0]         up_reg, up_next;
    logic [30:0]         lo_reg, lo_next;
    logic [15:0]         c5_reg, c5_next, cg_reg, cg_next, cc_reg, cc_next;

    // result register
    logic        ov_reg, ov_next;
    logic [15:0] otag_reg, otag_next;
    logic [1:0]  obase_reg, obase_next;
    logic [5:0]  opos_reg, opos_next;
    logic        odmg_reg, odmg_next;
    logic        olast_reg, olast_next;

    // memories
    logic                tw_we;
    logic [TW_IDX_W-1:0] tw_waddr, tw_raddr;
    logic [63:0]         tw_wdata, tw_rdata;
    logic                st_we;
    logic [AW-1:0]       st_waddr;
    logic [1:0]          st_wdata, st_rdata;
    logic                cv_we;
    logic [15:0]         c5_rdata;
    logic [31:0]         cgc_rdata;
    logic [AW-1:0]       d3_addr;

    drg_ram #(.WIDTH(64), .DEPTH(TW_N)) u_tw_ram (
        .clk(clk), .we(tw_we), .waddr(tw_waddr), .wdata(tw_wdata),
        .raddr(tw_raddr), .rdata(tw_rdata)
    );

    drg_ram #(.WIDTH(2), .DEPTH(MAX_READ_LENGTH)) u_store_ram (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(k_reg[AW-1:0]), .rdata(st_rdata)
    );

    drg_ram #(.WIDTH(16), .DEPTH(MAX_READ_LENGTH)) u_five_ram (
        .clk(clk), .we(cv_we), .waddr(cnt_reg[AW-1:0]), .wdata(c5_reg),
        .raddr(k_reg[AW-1:0]), .rdata(c5_rdata)
    );

    drg_ram #(.WIDTH(32), .DEPTH(MAX_READ_LENGTH)) u_three_ram (
        .clk(clk), .we(cv_we), .waddr(cnt_reg[AW-1:0]), .wdata({cc_reg, cg_reg}),
        .raddr(d3_addr), .rdata(cgc_rdata)
    );

    // APB
    logic       cfg_we;
    logic [2:0] cfg_idx;
    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_we  = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_idx)
            REG_SEED:    prdata = seed_reg;
            REG_LENGTH:  prdata = 64'(length_reg);
            REG_COMP:    prdata = 64'(comp_reg);
            REG_FIVE_CT: prdata = 64'(five_cfg_reg);
            REG_GA3:     prdata = 64'(ga_cfg_reg);
            REG_CT3:     prdata = 64'(ct_cfg_reg);
            REG_RATES:   prdata = rates_reg;
            default:     prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg     <= RST_SEED;
            length_reg   <= RST_LENGTH;
            comp_reg     <= RST_COMP;
            five_cfg_reg <= RST_FIVE_CT;
            ga_cfg_reg   <= RST_GA3;
            ct_cfg_reg   <= RST_CT3;
            rates_reg    <= RST_RATES;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_SEED:    seed_reg     <= pwdata;
                REG_LENGTH:  length_reg   <= pwdata[6:0];
                REG_COMP:    comp_reg     <= pwdata[32:0];
                REG_FIVE_CT: five_cfg_reg <= pwdata[31:0];
                REG_GA3:     ga_cfg_reg   <= pwdata[31:0];
                REG_CT3:     ct_cfg_reg   <= pwdata[31:0];
                REG_RATES:   rates_reg    <= pwdata;
                default:     ;
            endcase
        end
    end

    // field views
    logic [15:0] gc, frac, bg_c, bg_g, oxo, dep;
    logic        single;
    assign gc     = comp_reg[15:0];
    assign frac   = comp_reg[31:16];
    assign single = comp_reg[32];
    assign bg_c   = rates_reg[15:0];
    assign bg_g   = rates_reg[31:16];
    assign oxo    = rates_reg[47:32];
    assign dep    = rates_reg[63:48];

    logic go_five, go_ct, go_ga, go_oxo;
    assign go_five = anc_reg && (five_cfg_reg[15:0] != 16'd0);
    assign go_ct   = anc_reg && single && (ct_cfg_reg[15:0] != 16'd0);
    assign go_ga   = anc_reg && (ga_cfg_reg[15:0] != 16'd0);
    assign go_oxo  = anc_reg && (oxo != 16'd0);

    // draw evaluation
    logic [63:0]      tw_x;
    logic [PB-1:0]    top, p_scaled, gcs;
    logic [15:0]      p16;
    logic [PB+15:0]   p_wide, gc_wide;
    logic [PB+1:0]    u2, full, lim0, lim2;
    logic             hit;
    logic [1:0]       bsel;
    logic [1:0]       b0;

    always_comb
    begin
        case (op_reg)
            OP_ANC:  p16 = frac;
            OP_DEP:  p16 = dep;
            OP_BGC:  p16 = bg_c;
            OP_FIVE: p16 = five_reg;
            OP_CT3:  p16 = ct_reg;
            OP_BGG:  p16 = bg_g;
            OP_GA3:  p16 = ga_reg;
            OP_OXO:  p16 = oxo;
            default: p16 = 16'd0;
        endcase
    end

    assign tw_x     = tw_temper(tw_rdata);
    assign top      = tw_x[63 -: PB];
    assign p_wide   = {p16, PB'(0)};
    assign p_scaled = p_wide[PB+15:16];
    assign gc_wide  = {gc, PB'(0)};
    assign gcs      = gc_wide[PB+15:16];
    assign hit      = top < p_scaled;
    assign u2       = {1'b0, top, 1'b0};
    assign full     = (PB+2)'(1) << PB;
    assign lim0     = full - (PB+2)'(gcs);
    assign lim2     = full + (PB+2)'(gcs);

    always_comb
    begin
        if (u2 < lim0)
            bsel = BASE_A;
        else if (u2 < full)
            bsel = BASE_C;
        else if (u2 < lim2)
            bsel = BASE_G;
        else
            bsel = BASE_T;
    end

    assign b0 = (k_reg == '0) ? bsel : base0_reg;

    // seeding multiplier, one 32x32 product a cycle
    logic [63:0] seed_m;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    assign seed_m = pw_reg ^ (pw_reg >> 62);
    always_comb
    begin
        case (ph_reg)
            2'd0:    begin mul_a = seed_m[31:0];  mul_b = TW_SEED_MUL[31:0];  end
            2'd1:    begin mul_a = seed_m[31:0];  mul_b = TW_SEED_MUL[63:32]; end
            default: begin mul_a = seed_m[63:32]; mul_b = TW_SEED_MUL[31:0];  end
        endcase
    end
    assign prod = 64'(mul_a) * 64'(mul_b);

    // twister regeneration terms
    logic [63:0]         regen_y, regen_v;
    logic [TW_IDX_W-1:0] cnt_p1, cnt_pm;
    assign regen_y = {up_reg, lo_reg};
    assign regen_v = tw_rdata ^ (regen_y >> 1) ^ (regen_y[0] ? TW_MAG : 64'd0);
    assign cnt_p1  = (cnt_reg == TW_LAST) ? '0 : cnt_reg + 1'b1;
    assign cnt_pm  = (cnt_reg < TW_OFS) ? cnt_reg + TW_OFS : cnt_reg - TW_OFS;

    logic [CW-1:0] d3;
    assign d3      = len_reg - 1'b1 - k_reg;
    assign d3_addr = d3[AW-1:0];

    logic out_free;
    assign out_free = !ov_reg || m_tready;

    logic [CW-1:0] len_clamp;
    always_comb
    begin
        if (length_reg == 7'd0)
            len_clamp = CW'(1);
        else if (length_reg > 7'(MAX_READ_LENGTH))
            len_clamp = LEN_MAX;
        else
            len_clamp = CW'(length_reg);
    end

    assign s_tready = (st_reg == ST_IDLE);

    always_comb
    begin
        st_next           = st_reg;
        op_next           = op_reg;
        ph_next           = ph_reg;
        cnt_next          = cnt_reg;
        idx_next          = idx_reg;
        k_next            = k_reg;
        len_next          = len_reg;
        tag_next          = tag_reg;
        anc_next          = anc_reg;
        base0_next        = base0_reg;
        cur_next          = cur_reg;
        five_next         = five_reg;
        ga_next           = ga_reg;
        ct_next           = ct_reg;
        pw_next           = pw_reg;
        acc_next          = acc_reg;
        up_next           = up_reg;
        lo_next           = lo_reg;
        c5_next           = c5_reg;
        cg_next           = cg_reg;
        cc_next           = cc_reg;
        curves_valid_next = curves_valid_reg;
        tw_we             = 1'b0;
        tw_waddr          = cnt_reg;
        tw_wdata          = regen_v;
        tw_raddr          = idx_reg;
        st_we             = 1'b0;
        st_waddr          = k_reg[AW-1:0];
        st_wdata          = bsel;
        cv_we             = 1'b0;
        ov_next           = ov_reg && !m_tready;
        otag_next         = otag_reg;
        obase_next        = obase_reg;
        opos_next         = opos_reg;
        odmg_next         = odmg_reg;
        olast_next        = olast_reg;

        unique case (st_reg)
            ST_SEED:
            begin
                if (cnt_reg == '0)
                begin
                    tw_we    = 1'b1;
                    tw_wdata = seed_reg;
                    pw_next  = seed_reg;
                    cnt_next = cnt_reg + 1'b1;
                    ph_next  = 2'd0;
                end
                else
                begin
                    unique case (ph_reg)
                        2'd0:
                        begin
                            acc_next = prod;
                            ph_next  = 2'd1;
                        end
                        2'd1:
                        begin
                            acc_next = acc_reg + (prod << 32);
                            ph_next  = 2'd2;
                        end
                        default:
                        begin
                            tw_we    = 1'b1;
                            tw_wdata = acc_reg + (prod << 32) + 64'(cnt_reg);
                            pw_next  = tw_wdata;
                            ph_next  = 2'd0;
                            if (cnt_reg == TW_LAST)
                                st_next = ST_IDLE;
                            else
                                cnt_next = cnt_reg + 1'b1;
                        end
                    endcase
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    tag_next = s_tdata;
                    len_next = len_clamp;
                    op_next  = OP_ANC;
                    cnt_next = '0;
                    c5_next  = five_cfg_reg[15:0];
                    cg_next  = ga_cfg_reg[15:0];
                    cc_next  = ct_cfg_reg[15:0];
                    st_next  = curves_valid_reg ? ST_DRAW_A : ST_BUILD;
                end
            end
            ST_BUILD:
            begin
                // write entry cnt of all three curves, advance by the decay ratio
                cv_we    = 1'b1;
                c5_next  = 16'((32'(c5_reg) * 32'(five_cfg_reg[31:16])) >> 16);
                cg_next  = 16'((32'(cg_reg) * 32'(ga_cfg_reg[31:16])) >> 16);
                cc_next  = 16'((32'(cc_reg) * 32'(ct_cfg_reg[31:16])) >> 16);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == TW_IDX_W'(MAX_READ_LENGTH - 1))
                begin
                    curves_valid_next = 1'b1;
                    st_next           = ST_DRAW_A;
                end
            end
            ST_DRAW_A:
            begin
                if (idx_reg >= TW_END)
                begin
                    cnt_next = '0;
                    ph_next  = 2'd0;
                    st_next  = ST_REGEN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    st_next  = ST_DRAW_B;
                end
            end
            ST_REGEN:
            begin
                unique case (ph_reg)
                    2'd0:
                    begin
                        tw_raddr = cnt_reg;
                        ph_next  = 2'd1;
                    end
                    2'd1:
                    begin
                        up_next  = tw_rdata[63:31];
                        tw_raddr = cnt_p1;
                        ph_next  = 2'd2;
                    end
                    2'd2:
                    begin
                        lo_next  = tw_rdata[30:0];
                        tw_raddr = cnt_pm;
                        ph_next  = 2'd3;
                    end
                    default:
                    begin
                        tw_we   = 1'b1;
                        ph_next = 2'd0;
                        if (cnt_reg == TW_LAST)
                        begin
                            idx_next = '0;
                            st_next  = ST_DRAW_A;
                        end
                        else
                            cnt_next = cnt_reg + 1'b1;
                    end
                endcase
            end
            ST_DRAW_B:
            begin
                st_next = ST_DRAW_A;
                case (op_reg)
                    OP_ANC:
                    begin
                        anc_next = hit;
                        k_next   = '0;
                        op_next  = OP_BASE;
                    end
                    OP_BASE:
                    begin
                        st_we      = 1'b1;
                        base0_next = b0;
                        if (k_reg == len_reg - 1'b1)
                        begin
                            k_next = '0;
                            if (anc_reg && dep != 16'd0 && (b0 == BASE_C || b0 == BASE_T))
                                op_next = OP_DEP;
                            else
                                st_next = ST_FETCH;
                        end
                        else
                            k_next = k_reg + 1'b1;
                    end
                    OP_DEP:
                    begin
                        if (hit)
                            op_next = OP_DEPB;
                        else
                            st_next = ST_FETCH;
                    end
                    OP_DEPB:
                    begin
                        st_we    = 1'b1;
                        st_waddr = '0;
                        st_wdata = ({1'b0, top} < full - (PB+2)'(gcs)) ? BASE_A : BASE_G;
                        st_next  = ST_FETCH;
                    end
                    OP_BGC, OP_FIVE:
                    begin
                        if (hit)
                        begin
                            cur_next = BASE_T;
                            st_next  = ST_EMIT;
                        end
                        else if (op_reg == OP_BGC && go_five)
                            op_next = OP_FIVE;
                        else if (go_ct)
                            op_next = OP_CT3;
                        else
                        begin
                            cur_next = BASE_C;
                            st_next  = ST_EMIT;
                        end
                    end
                    OP_CT3:
                    begin
                        cur_next = hit ? BASE_T : BASE_C;
                        st_next  = ST_EMIT;
                    end
                    OP_BGG, OP_GA3:
                    begin
                        if (hit)
                        begin
                            cur_next = BASE_A;
                            st_next  = ST_EMIT;
                        end
                        else if (op_reg == OP_BGG && go_ga)
                            op_next = OP_GA3;
                        else if (go_oxo)
                            op_next = OP_OXO;
                        else
                        begin
                            cur_next = BASE_G;
                            st_next  = ST_EMIT;
                        end
                    end
                    default:
                    begin
                        cur_next = hit ? BASE_T : BASE_G;
                        st_next  = ST_EMIT;
                    end
                endcase
            end
            ST_FETCH:
            begin
                st_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                five_next = c5_rdata;
                ga_next   = cgc_rdata[15:0];
                ct_next   = cgc_rdata[31:16];
                cur_next  = st_rdata;
                if (st_rdata == BASE_C)
                begin
                    op_next = OP_BGC;
                    st_next = ST_DRAW_A;
                end
                else if (st_rdata == BASE_G)
                begin
                    op_next = OP_BGG;
                    st_next = ST_DRAW_A;
                end
                else
                    st_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    otag_next  = tag_reg;
                    obase_next = cur_reg;
                    opos_next  = 6'(k_reg);
                    odmg_next  = anc_reg;
                    olast_next = (k_reg == len_reg - 1'b1);
                    if (k_reg == len_reg - 1'b1)
                        st_next = ST_IDLE;
                    else
                    begin
                        k_next  = k_reg + 1'b1;
                        st_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        // user writes config only while idle, unchecked; reseed restarts the seeding pass
        if (cfg_we && cfg_idx == REG_SEED)
        begin
            st_next  = ST_SEED;
            cnt_next = '0;
            ph_next  = 2'd0;
            idx_next = TW_END;
        end
        if (cfg_we && (cfg_idx == REG_FIVE_CT || cfg_idx == REG_GA3 || cfg_idx == REG_CT3))
            curves_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg           <= ST_SEED;
            op_reg           <= OP_ANC;
            ph_reg           <= 2'd0;
            cnt_reg          <= '0;
            idx_reg          <= TW_END;
            k_reg            <= '0;
            curves_valid_reg <= 1'b0;
            ov_reg           <= 1'b0;
        end
        else
        begin
            st_reg           <= st_next;
            op_reg           <= op_next;
            ph_reg           <= ph_next;
            cnt_reg          <= cnt_next;
            idx_reg          <= idx_next;
            k_reg            <= k_next;
            curves_valid_reg <= curves_valid_next;
            ov_reg           <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        tag_reg   <= tag_next;
        anc_reg   <= anc_next;
        base0_reg <= base0_next;
        cur_reg   <= cur_next;
        five_reg  <= five_next;
        ga_reg    <= ga_next;
        ct_reg    <= ct_next;
        pw_reg    <= pw_next;
        acc_reg   <= acc_next;
        up_reg    <= up_next;
        lo_reg    <= lo_next;
        c5_reg    <= c5_next;
        cg_reg    <= cg_next;
        cc_reg    <= cc_next;
        otag_reg  <= otag_next;
        obase_reg <= obase_next;
        opos_reg  <= opos_next;
        odmg_reg  <= odmg_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {7'd0, odmg_reg, opos_reg, obase_reg, otag_reg};
    assign m_tlast  = olast_reg;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready || st_reg == ST_SEED)
        else $error("request accepted but sequencer stayed idle");

    a_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= TW_END)
        else $error("twister index beyond the state size");

    a_last_ends_read: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_EMIT && out_free && k_reg == len_reg - 1'b1 && !cfg_we
        |=> st_reg == ST_IDLE && m_tvalid && m_tlast)
        else $error("last base sent but read not closed");
`endif

endmodule

### sim/damaged_read_generator_checker.sv
// Checker for the damaged read generator: predicts every read and compares output beats.
module damaged_read_generator_checker
    import drg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          bases_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] tag;
        logic [1:0]  base;
        logic [5:0]  pos;
        logic        damaged;
        logic        last;
    } base_beat_t;

    base_beat_t base_expect[$];

    logic [63:0] seed_q;
    logic [6:0]  length_q;
    logic [32:0] comp_q;
    logic [31:0] five_q;
    logic [31:0] ga3_q;
    logic [31:0] ct3_q;
    logic [63:0] rates_q;

    logic [63:0] mt_words [0:TW_N-1];
    int unsigned mt_pos;
    logic [15:0] five_tab [0:63];
    logic [15:0] ga_tab [0:63];
    logic [15:0] ct_tab [0:63];
    logic        tabs_ok;
    logic [1:0]  seq [0:63];

    assign pending = base_expect.size();

    function void mt_reseed(input logic [63:0] s);
        mt_words[0] = s;
        for (int k = 1; k < TW_N; k++)
            mt_words[k] = TW_SEED_MUL * (mt_words[k-1] ^ (mt_words[k-1] >> 62)) + 64'(k);
        mt_pos = TW_N;
    endfunction

    // top 16 bits of the next tempered twister word
    function logic [15:0] draw16();
        logic [63:0] y;
        logic [63:0] v;
        if (mt_pos >= TW_N)
        begin
            for (int k = 0; k < TW_N; k++)
            begin
                y = (mt_words[k] & 64'hFFFF_FFFF_8000_0000) |
                    (mt_words[(k + 1) % TW_N] & 64'h0000_0000_7FFF_FFFF);
                v = mt_words[(k + TW_M) % TW_N] ^ (y >> 1);
                if (y[0])
                    v = v ^ TW_MAG;
                mt_words[k] = v;
            end
            mt_pos = 0;
        end
        y = mt_words[mt_pos];
        mt_pos++;
        y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
        y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
        y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
        y = y ^ (y >> 43);
        return y[63:48];
    endfunction

    function logic hit(input logic [15:0] p);
        return draw16() < p;
    endfunction

    function void build_tab(output logic [15:0] t [0:63], input logic [31:0] r);
        t[0] = r[15:0];
        for (int d = 1; d < 64; d++)
            t[d] = 16'((32'(t[d-1]) * 32'(r[31:16])) >> 16);
    endfunction

    function void predict_read(input logic [15:0] tag);
        int unsigned len;
        int unsigned full;
        int unsigned gc;
        int unsigned u2;
        logic        anc;
        logic        single;
        logic        done;
        base_beat_t  b;
        len = (length_q == 0) ? 1 : (length_q > 64) ? 64 : length_q;
        full = 65536;
        gc = comp_q[15:0];
        single = comp_q[32];
        if (!tabs_ok)
        begin
            build_tab(five_tab, five_q);
            build_tab(ga_tab, ga3_q);
            build_tab(ct_tab, ct3_q);
            tabs_ok = 1'b1;
        end
        anc = hit(comp_q[31:16]);
        for (int k = 0; k < len; k++)
        begin
            u2 = 2 * int'(draw16());
            if (u2 < full - gc)      seq[k] = BASE_A;
            else if (u2 < full)      seq[k] = BASE_C;
            else if (u2 < full + gc) seq[k] = BASE_G;
            else                     seq[k] = BASE_T;
        end
        // depurination replaces a pyrimidine at the 5' end
        if (anc && rates_q[63:48] != 0 && (seq[0] == BASE_C || seq[0] == BASE_T))
            if (hit(rates_q[63:48]))
                seq[0] = (int'(draw16()) < full - gc) ? BASE_A : BASE_G;
        for (int k = 0; k < len; k++)
        begin
            done = 1'b0;
            if (seq[k] == BASE_C)
            begin
                if (hit(rates_q[15:0]))
                    done = 1'b1;
                else if (anc && five_tab[0] != 0 && hit(five_tab[k]))
                    done = 1'b1;
                else if (anc && single && ct_tab[0] != 0 && hit(ct_tab[len-1-k]))
                    done = 1'b1;
                if (done)
                    seq[k] = BASE_T;
            end
            else if (seq[k] == BASE_G)
            begin
                if (hit(rates_q[31:16]))
                    seq[k] = BASE_A;
                else if (anc && ga_tab[0] != 0 && hit(ga_tab[len-1-k]))
                    seq[k] = BASE_A;
                else if (anc && rates_q[47:32] != 0 && hit(rates_q[47:32]))
                    seq[k] = BASE_T;
            end
        end
        for (int k = 0; k < len; k++)
        begin
            b.tag = tag;
            b.base = seq[k];
            b.pos = 6'(k);
            b.damaged = anc;
            b.last = (k + 1 == len);
            base_expect.push_back(b);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        base_beat_t e;
        if (!rst_n)
        begin
            seed_q   <= RST_SEED;
            length_q <= RST_LENGTH;
            comp_q   <= RST_COMP;
            five_q   <= RST_FIVE_CT;
            ga3_q    <= RST_GA3;
            ct3_q    <= RST_CT3;
            rates_q  <= RST_RATES;
            mt_reseed(RST_SEED);
            tabs_ok = 1'b0;
            base_expect.delete();
            fail_count <= 0;
            bases_seen <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[5:3])
                    REG_SEED:
                    begin
                        seed_q <= pwdata;
                        mt_reseed(pwdata);
                    end
                    REG_LENGTH:  length_q <= pwdata[6:0];
                    REG_COMP:    comp_q <= pwdata[32:0];
                    REG_FIVE_CT:
                    begin
                        five_q <= pwdata[31:0];
                        tabs_ok = 1'b0;
                    end
                    REG_GA3:
                    begin
                        ga3_q <= pwdata[31:0];
                        tabs_ok = 1'b0;
                    end
                    REG_CT3:
                    begin
                        ct3_q <= pwdata[31:0];
                        tabs_ok = 1'b0;
                    end
                    REG_RATES:   rates_q <= pwdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_read(s_tdata);
            if (m_tvalid && m_tready)
            begin
                bases_seen <= bases_seen + 1;
                if (base_expect.size() == 0)
                begin
                    $error("unexpected base beat: tdata %h", m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = base_expect.pop_front();
                    if (m_tdata[15:0] !== e.tag || m_tdata[17:16] !== e.base ||
                        m_tdata[23:18] !== e.pos || m_tdata[24] !== e.damaged ||
                        m_tlast !== e.last)
                        fail_count <= fail_count + 1;
                    if (m_tdata[15:0] !== e.tag)
                        $error("read_tag: expected %h, got %h", e.tag, m_tdata[15:0]);
                    if (m_tdata[17:16] !== e.base)
                        $error("base: expected %0d, got %0d", e.base, m_tdata[17:16]);
                    if (m_tdata[23:18] !== e.pos)
                        $error("position: expected %0d, got %0d", e.pos, m_tdata[23:18]);
                    if (m_tdata[24] !== e.damaged)
                        $error("is_damaged: expected %b, got %b", e.damaged, m_tdata[24]);
                    if (m_tlast !== e.last)
                        $error("last: expected %b, got %b", e.last, m_tlast);
                end
            end
        end
    end

endmodule

### sim/tb.sv
// Top of the damaged read generator testbench: clock, reset, stimulus and verdict.
module tb;
    import drg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int IDLE_LIMIT = 20000;
    localparam int STALL_CYCLES = 3000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    int  fail_count;
    int  pending;
    int  bases_seen;
    int  reads_sent;
    int  quiet_cycles;
    bit  calm;
    bit  stall_req;
    int  rx_gap;

    damaged_read_generator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    damaged_read_generator_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending(pending), .bases_seen(bases_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 3);
    endfunction

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        rx_gap = 0;
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                m_tready = 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
                stall_req = 1'b0;
                m_tready = 1'b1;
            end
            else if (rx_gap > 0)
            begin
                m_tready = 1'b0;
                rx_gap--;
            end
            else
            begin
                m_tready = 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    rx_gap = pick_gap();
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // called at a falling edge; returns at a falling edge
    task automatic send_read(input logic [15:0] t);
        s_tdata = t;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        reads_sent++;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
    endtask

    task automatic send_burst(input int n);
        for (int i = 0; i < n; i++)
            send_read(16'($urandom_range(0, 65535)));
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_all(input logic [63:0] seed, input logic [6:0] len,
                           input logic [32:0] comp, input logic [31:0] five,
                           input logic [31:0] ga, input logic [31:0] ct,
                           input logic [63:0] rates);
        reg_write(REG_SEED, seed);
        reg_write(REG_LENGTH, {57'd0, len});
        reg_write(REG_COMP, {31'd0, comp});
        reg_write(REG_FIVE_CT, {32'd0, five});
        reg_write(REG_GA3, {32'd0, ga});
        reg_write(REG_CT3, {32'd0, ct});
        reg_write(REG_RATES, rates);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b1;
        stall_req = 1'b0;
        reads_sent = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings, tag extremes
        send_read(16'h0000);
        send_read(16'hFFFF);
        send_read(16'h5A5A);
        drain();

        // nearly all damaged, AT-only bases, top depurination and oxo rates
        set_all({$urandom, $urandom}, 7'd1, {1'b1, 16'hFFFF, 16'h0000},
                32'hFFFF_FFFF, 32'h0000_FFFF, 32'h8000_FFFF, 64'hFFFF_FFFF_0000_0000);
        send_burst(2);
        drain();
        reg_write(REG_LENGTH, 64'd64);
        send_burst(2);
        drain();

        // almost only GC bases, maximal rates
        reg_write(REG_COMP, {31'd0, 1'b1, 16'h8000, 16'hFFFF});
        reg_write(REG_RATES, 64'hFFFF_FFFF_FFFF_FFFF);
        send_burst(3);
        drain();

        // length zero, above range, just over range, unused register index
        reg_write(REG_LENGTH, 64'd0);
        reg_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_burst(2);
        drain();
        reg_write(REG_LENGTH, 64'd127);
        send_burst(2);
        drain();
        reg_write(REG_LENGTH, 64'd65);
        send_burst(1);
        drain();

        // zero amplitudes, depurination and oxo rates skip their draws
        set_all(64'd0, 7'd20, {1'b1, 16'hFFFF, 16'h7000}, 32'h1234_0000,
                32'hFFFF_0000, 32'h0000_0000, 64'h0000_0000_0000_0000);
        send_burst(3);
        drain();
        reg_write(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_burst(2);
        drain();

        // random phases, mostly short reads
        calm = 1'b0;
        for (int ph = 0; ph < 10; ph++)
        begin
            set_all({$urandom, $urandom},
                    ($urandom_range(0, 5) == 0) ? 7'd64 : 7'($urandom_range(1, 24)),
                    {1'($urandom), 16'($urandom), 16'($urandom)},
                    $urandom, $urandom, $urandom,
                    ($urandom_range(0, 2) == 0) ? {$urandom, $urandom}
                        : {16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)),
                           16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000))});
            if (ph == 4)
                stall_req = 1'b1;
            if (ph == 7)
                calm = 1'b1;
            send_burst(20);
            calm = (ph == 6);
            drain();
        end

        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        $display("run: %0d reads over directed and random settings, %0d bases checked",
                 reads_sent, bases_seen);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
